@@ rtl/fmbq_pkg.sv @@
package fmbq_pkg;

    // Default sizes of the store.
    localparam int DEPTH_DEF      = 32;
    localparam int VALUE_BITS_DEF = 31;

    // Fixed field widths at the ports.
    localparam int OP_BITS     = 3;
    localparam int PUSH_BITS   = 31;
    localparam int POP_BITS    = 31;
    localparam int STATUS_BITS = 2;
    localparam int FILL_BITS   = 6;

    // Operation codes carried by a request.
    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_MIDDLE = 3'd1,
        OP_PUSH_BACK   = 3'd2,
        OP_POP_FRONT   = 3'd3,
        OP_POP_MIDDLE  = 3'd4,
        OP_POP_BACK    = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new request
        logic rd_pop;   // read the entry being removed
        logic rd_move;  // read the next entry to shift
        logic wr_move;  // write the shifted entry and step the cursor
        logic wr_val;   // write the pushed value at its position
        logic cap_pop;  // capture the removed value
        logic finish;   // update the count and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic do_ins;         // current request inserts a value
        logic do_rem;         // current request removes a value
        logic at_pos;         // cursor sits at the insert position
        logic next_at_pos;    // cursor will reach the insert position after this move
        logic rem_more;       // an entry behind the cursor still has to move forward
        logic rem_more_next;  // the same, after the cursor steps once more
        logic out_free;       // result register can take a new result
    } stat_t;

endpackage

@@ rtl/fmbq_ctrl.sv @@
module fmbq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  fmbq_pkg::stat_t st,
    output fmbq_pkg::cmd_t  cmd,
    output logic            req_stall
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_POP_RD   = 8'b0000_0100,
        S_POP_CAP  = 8'b0000_1000,
        S_MOVE_RD  = 8'b0001_0000,
        S_MOVE_WR  = 8'b0010_0000,
        S_INS_WR   = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new request is taken only while no other one is in progress.
    assign req_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.do_ins)
                begin
                    state_next = st.at_pos ? S_INS_WR : S_MOVE_RD;
                end
                else if (st.do_rem)
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_POP_RD:
            begin
                cmd.rd_pop = 1'b1;
                state_next = S_POP_CAP;
            end
            S_POP_CAP:
            begin
                cmd.cap_pop = 1'b1;
                state_next  = st.rem_more ? S_MOVE_RD : S_FIN;
            end
            S_MOVE_RD:
            begin
                cmd.rd_move = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.wr_move = 1'b1;
                if (st.do_ins)
                begin
                    state_next = st.next_at_pos ? S_INS_WR : S_MOVE_RD;
                end
                else
                begin
                    state_next = st.rem_more_next ? S_MOVE_RD : S_FIN;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_val = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/fmbq_dpath.sv @@
module fmbq_dpath
#(
    parameter int DEPTH      = fmbq_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = fmbq_pkg::VALUE_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fmbq_pkg::cmd_t                   cmd,
    output fmbq_pkg::stat_t                  st,
    input  logic [fmbq_pkg::OP_BITS-1:0]     op,
    input  logic [fmbq_pkg::PUSH_BITS-1:0]   push_value,
    input  logic                             res_stall,
    output logic                             res_valid,
    output logic [fmbq_pkg::POP_BITS-1:0]    pop_value,
    output logic [fmbq_pkg::STATUS_BITS-1:0] status,
    output logic [fmbq_pkg::FILL_BITS-1:0]   fill_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    // Entry store, element 0 is the front.
    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic                  do_ins_reg;
    logic                  do_rem_reg;
    fmbq_pkg::status_t     item_status_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]         pos_reg;
    logic [CW-1:0]         cur_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [VALUE_BITS-1:0] popped_reg;
    logic [VALUE_BITS-1:0] res_pop_reg;
    fmbq_pkg::status_t     res_status_reg;
    logic [CW-1:0]         res_fill_reg;
    logic                  res_valid_reg;

    logic                  full;
    logic                  empty;
    logic                  acc_ins;
    logic                  acc_rem;
    fmbq_pkg::status_t     acc_status;
    logic [CW-1:0]         acc_pos;
    logic [CW-1:0]         cur_m1;
    logic [CW-1:0]         cur_p1;
    logic                  mem_re;
    logic                  mem_we;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Request decode: target position and error status.
    always_comb
    begin
        acc_ins    = 1'b0;
        acc_rem    = 1'b0;
        acc_status = fmbq_pkg::ST_OK;
        acc_pos    = '0;
        unique case (fmbq_pkg::op_t'(op))
            fmbq_pkg::OP_PUSH_FRONT:
            begin
                acc_pos = '0;
                if (full) acc_status = fmbq_pkg::ST_FULL;
                else      acc_ins    = 1'b1;
            end
            fmbq_pkg::OP_PUSH_MIDDLE:
            begin
                acc_pos = count_reg >> 1;
                if (full) acc_status = fmbq_pkg::ST_FULL;
                else      acc_ins    = 1'b1;
            end
            fmbq_pkg::OP_PUSH_BACK:
            begin
                acc_pos = count_reg;
                if (full) acc_status = fmbq_pkg::ST_FULL;
                else      acc_ins    = 1'b1;
            end
            fmbq_pkg::OP_POP_FRONT:
            begin
                acc_pos = '0;
                if (empty) acc_status = fmbq_pkg::ST_EMPTY;
                else       acc_rem    = 1'b1;
            end
            fmbq_pkg::OP_POP_MIDDLE:
            begin
                acc_pos = (count_reg - 1'b1) >> 1;
                if (empty) acc_status = fmbq_pkg::ST_EMPTY;
                else       acc_rem    = 1'b1;
            end
            fmbq_pkg::OP_POP_BACK:
            begin
                acc_pos = count_reg - 1'b1;
                if (empty) acc_status = fmbq_pkg::ST_EMPTY;
                else       acc_rem    = 1'b1;
            end
            default:
            begin
                acc_pos = '0;
            end
        endcase
    end

    // Cursor neighbors used while shifting.
    assign cur_m1 = cur_reg - 1'b1;
    assign cur_p1 = cur_reg + 1'b1;

    // Status toward the controller.
    assign st.do_ins        = do_ins_reg;
    assign st.do_rem        = do_rem_reg;
    assign st.at_pos        = (cur_reg == pos_reg);
    assign st.next_at_pos   = (cur_m1 == pos_reg);
    assign st.rem_more      = (({1'b0, cur_reg} + (CW + 1)'(1)) < {1'b0, count_reg});
    assign st.rem_more_next = (({1'b0, cur_reg} + (CW + 1)'(2)) < {1'b0, count_reg});
    assign st.out_free      = !res_valid_reg || !res_stall;

    // Request capture and cursor control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            do_ins_reg <= 1'b0;
            do_rem_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            do_ins_reg <= acc_ins;
            do_rem_reg <= acc_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_status_reg <= acc_status;
            val_reg         <= VALUE_BITS'(push_value);
            pos_reg         <= acc_pos;
            cur_reg         <= acc_ins ? count_reg : acc_pos;
        end
        else if (cmd.wr_move)
        begin
            cur_reg <= do_ins_reg ? cur_m1 : cur_p1;
        end
        if (cmd.cap_pop)
        begin
            popped_reg <= rd_data_reg;
        end
    end

    // Memory port: inserts move entries backward, removals move them forward.
    assign mem_re  = cmd.rd_pop || cmd.rd_move;
    assign mem_we  = cmd.wr_move || cmd.wr_val;
    assign rd_addr = cmd.rd_pop ? pos_reg[AW-1:0]
                   : (do_ins_reg ? cur_m1[AW-1:0] : cur_p1[AW-1:0]);
    assign wr_addr = cmd.wr_val ? pos_reg[AW-1:0] : cur_reg[AW-1:0];
    assign wr_data = cmd.wr_val ? val_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Fill count after the current request.
    always_comb
    begin
        if (do_ins_reg)      count_next = count_reg + 1'b1;
        else if (do_rem_reg) count_next = count_reg - 1'b1;
        else                 count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_pop_reg    <= do_rem_reg ? popped_reg : '0;
            res_status_reg <= item_status_reg;
            res_fill_reg   <= count_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign pop_value  = fmbq_pkg::POP_BITS'(res_pop_reg);
    assign status     = res_status_reg;
    assign fill_count = fmbq_pkg::FILL_BITS'(res_fill_reg);

endmodule

@@ rtl/front_middle_back_queue.sv @@
// Ordered store of up to DEPTH values kept in a single-port memory with element 0 at the
// front. Each request pushes a value at the front, middle or back, or pops one from there,
// and always returns one result with the popped value, a status and the fill count. One
// request is in progress at a time, and every entry that a request shifts needs one memory
// read and one memory write on the shared port. Back operations shift nothing, front
// operations shift every stored entry, and middle operations shift about half of them.
// Errors and unused codes go from dispatch straight to the finish state. A finished
// result waits in an output register, so the next request is taken while the previous
// result has not yet been collected.
module front_middle_back_queue
#(
    parameter int DEPTH      = fmbq_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = fmbq_pkg::VALUE_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [fmbq_pkg::OP_BITS-1:0]     op,
    input  logic [fmbq_pkg::PUSH_BITS-1:0]   push_value,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [fmbq_pkg::POP_BITS-1:0]    pop_value,
    output logic [fmbq_pkg::STATUS_BITS-1:0] status,
    output logic [fmbq_pkg::FILL_BITS-1:0]   fill_count
);

    fmbq_pkg::cmd_t  cmd;
    fmbq_pkg::stat_t st;

    // Sequencer.
    fmbq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .st        (st),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    // Storage, cursor and result register.
    fmbq_dpath
    #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .op         (op),
        .push_value (push_value),
        .res_stall  (res_stall),
        .res_valid  (res_valid),
        .pop_value  (pop_value),
        .status     (status),
        .fill_count (fill_count)
    );

    // An accepted request raises the stall in the cycle after it is taken.
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while another was in progress");

    // A dropped push never reports a value.
    a_full_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == fmbq_pkg::ST_FULL) |-> (pop_value == '0))
        else $error("full status with a nonzero value");

    // A pop on an empty store reports an empty store and no value.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == fmbq_pkg::ST_EMPTY) |-> (fill_count == '0) && (pop_value == '0))
        else $error("empty status with stored values");

    // The result register only changes when the sequencer finishes a request.
    a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> st.out_free)
        else $error("result overwritten before it was taken");

endmodule
